### rtl/bdlp_pkg.sv
// shared types and constants for the button debounce and long press block
package bdlp_pkg;

    localparam int DEF_NUM_BUTTONS = 5;
    localparam int DEF_COUNT_WIDTH = 16;
    localparam int CFG_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CFG_WIDTH-1:0] SETTLE_RESET = 16'd20;
    localparam logic [CFG_WIDTH-1:0] REPEAT_RESET = 16'd500;
    localparam logic [CFG_WIDTH-1:0] LONG_RESET   = 16'd3000;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_SETTLE_TICKS = 2'd0,
        REG_REPEAT_TICKS = 2'd1,
        REG_LONG_TICKS   = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        EV_PRESSED  = 2'd0,
        EV_RELEASED = 2'd1,
        EV_REPEAT   = 2'd2,
        EV_LONG     = 2'd3
    } event_kind_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] settle_ticks;
        logic [CFG_WIDTH-1:0] repeat_ticks;
        logic [CFG_WIDTH-1:0] long_ticks;
    } cfg_t;

endpackage

### rtl/bdlp_front.sv
// front part: edge detection, settle counter and hold counters, one tick per cycle while tick_fire is high
module bdlp_front
    import bdlp_pkg::*;
#(
    parameter int NUM_BUTTONS = DEF_NUM_BUTTONS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     tick_fire,
    input  logic [NUM_BUTTONS-1:0]   levels,
    output logic                     push,
    output logic [4*NUM_BUTTONS-1:0] push_data
);

    localparam int CW = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [NUM_BUTTONS-1:0] prev_reg;
    logic [NUM_BUTTONS-1:0] pending_reg, pending_next;
    logic [NUM_BUTTONS-1:0] held_reg, held_next;
    logic                   active_reg, active_next;
    logic [COUNT_WIDTH-1:0] settle_reg, settle_next;
    logic [COUNT_WIDTH-1:0] hold_reg [NUM_BUTTONS];
    logic [COUNT_WIDTH-1:0] hold_next [NUM_BUTTONS];
    logic [COUNT_WIDTH-1:0] phase_reg [NUM_BUTTONS];
    logic [COUNT_WIDTH-1:0] phase_next [NUM_BUTTONS];

    logic [NUM_BUTTONS-1:0] edges;
    logic [NUM_BUTTONS-1:0] smask;
    logic [NUM_BUTTONS-1:0] slev;
    logic [NUM_BUTTONS-1:0] held_mid;
    logic [NUM_BUTTONS-1:0] rmask;
    logic [NUM_BUTTONS-1:0] lmask;
    logic [COUNT_WIDTH-1:0] settle_inc;
    logic [CW-1:0]          lim;
    logic [CW-1:0]          rep;
    logic [CW-1:0]          lng;
    logic                   sample;

    always_comb
    begin
        lim = (cfg.settle_ticks == '0) ? CW'(1) : CW'(cfg.settle_ticks);
        rep = (cfg.repeat_ticks == '0) ? CW'(1) : CW'(cfg.repeat_ticks);
        lng = CW'(cfg.long_ticks);
        edges = (levels ^ prev_reg) & ~pending_reg;
        settle_inc = (settle_reg == CNT_MAX) ? settle_reg : settle_reg + 1'b1;
        sample = 1'b0;
        pending_next = pending_reg;
        active_next = active_reg;
        settle_next = settle_reg;
        if (edges != '0)
        begin
            pending_next = pending_reg | edges;
            active_next = 1'b1;
            settle_next = '0;
        end
        else if (active_reg)
        begin
            if (CW'(settle_inc) >= lim)
            begin
                sample = 1'b1;
                pending_next = '0;
                active_next = 1'b0;
                settle_next = '0;
            end
            else
            begin
                settle_next = settle_inc;
            end
        end
        smask = sample ? pending_reg : '0;
        slev = smask & levels;
        held_mid = (held_reg & ~smask) | slev;
        held_next = held_mid;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            rmask[i] = 1'b0;
            lmask[i] = 1'b0;
            hold_next[i] = '0;
            phase_next[i] = '0;
            if (held_mid[i])
            begin
                hold_next[i] = (hold_reg[i] == CNT_MAX) ? hold_reg[i] : hold_reg[i] + 1'b1;
                phase_next[i] = (phase_reg[i] == CNT_MAX) ? phase_reg[i] : phase_reg[i] + 1'b1;
                if (CW'(phase_next[i]) >= rep)
                begin
                    rmask[i] = 1'b1;
                    phase_next[i] = '0;
                end
                if (lng != '0 && CW'(hold_next[i]) == lng)
                begin
                    lmask[i] = 1'b1;
                    hold_next[i] = '0;
                    phase_next[i] = '0;
                    held_next[i] = 1'b0;
                end
            end
        end
    end

    assign push = tick_fire && ((smask | rmask | lmask) != '0);
    assign push_data = {smask, slev, rmask, lmask};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            pending_reg <= '0;
            held_reg <= '0;
            active_reg <= 1'b0;
            settle_reg <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                hold_reg[i] <= '0;
                phase_reg[i] <= '0;
            end
        end
        else if (tick_fire)
        begin
            prev_reg <= levels;
            pending_reg <= pending_next;
            held_reg <= held_next;
            active_reg <= active_next;
            settle_reg <= settle_next;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                hold_reg[i] <= hold_next[i];
                phase_reg[i] <= phase_next[i];
            end
        end
    end

endmodule

### rtl/bdlp_queue.sv
// short queue of per-tick event masks between front and back
module bdlp_queue
    import bdlp_pkg::*;
#(
    parameter int WIDTH = 4 * DEF_NUM_BUTTONS,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_reg;
    logic [AW-1:0]    rd_reg;
    logic [NW-1:0]    count_reg;

    assign full = (count_reg == NW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/bdlp_back.sv
// back part: drains the event masks of one tick, one event per cycle while event_ready is high
module bdlp_back
    import bdlp_pkg::*;
#(
    parameter int NUM_BUTTONS = DEF_NUM_BUTTONS,
    parameter int IW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_not_empty,
    input  logic [4*NUM_BUTTONS-1:0] q_data,
    output logic                     q_pop,
    output logic                     event_valid,
    input  logic                     event_ready,
    output logic [IW-1:0]            button_index,
    output logic [1:0]               event_kind,
    output logic                     last_event
);

    logic                   busy_reg;
    logic [NUM_BUTTONS-1:0] smask_reg, smask_next;
    logic [NUM_BUTTONS-1:0] slev_reg;
    logic [NUM_BUTTONS-1:0] rmask_reg, rmask_next;
    logic [NUM_BUTTONS-1:0] lmask_reg, lmask_next;
    logic                   valid_reg;
    logic [IW-1:0]          index_reg, index_next;
    event_kind_t            kind_reg, kind_next;
    logic                   last_reg, last_next;
    logic [NUM_BUTTONS-1:0] hmask;
    logic                   found;
    logic                   advance;

    assign q_pop = !busy_reg && q_not_empty;
    assign advance = busy_reg && (!valid_reg || event_ready);
    assign hmask = rmask_reg | lmask_reg;

    always_comb
    begin
        smask_next = smask_reg;
        rmask_next = rmask_reg;
        lmask_next = lmask_reg;
        index_next = '0;
        kind_next = EV_PRESSED;
        found = 1'b0;
        if (smask_reg != '0)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                if (!found && smask_reg[i])
                begin
                    found = 1'b1;
                    index_next = IW'(i);
                    kind_next = slev_reg[i] ? EV_PRESSED : EV_RELEASED;
                    smask_next[i] = 1'b0;
                end
            end
        end
        else
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                if (!found && hmask[i])
                begin
                    found = 1'b1;
                    index_next = IW'(i);
                    if (rmask_reg[i])
                    begin
                        kind_next = EV_REPEAT;
                        rmask_next[i] = 1'b0;
                    end
                    else
                    begin
                        kind_next = EV_LONG;
                        lmask_next[i] = 1'b0;
                    end
                end
            end
        end
        last_next = ((smask_next | rmask_next | lmask_next) == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            valid_reg <= 1'b0;
            smask_reg <= '0;
            slev_reg <= '0;
            rmask_reg <= '0;
            lmask_reg <= '0;
            index_reg <= '0;
            kind_reg <= EV_PRESSED;
            last_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                busy_reg <= 1'b1;
                {smask_reg, slev_reg, rmask_reg, lmask_reg} <= q_data;
            end
            else if (advance)
            begin
                busy_reg <= !last_next;
                smask_reg <= smask_next;
                rmask_reg <= rmask_next;
                lmask_reg <= lmask_next;
            end
            if (advance)
            begin
                valid_reg <= 1'b1;
                index_reg <= index_next;
                kind_reg <= kind_next;
                last_reg <= last_next;
            end
            else if (event_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign event_valid = valid_reg;
    assign button_index = index_reg;
    assign event_kind = kind_reg;
    assign last_event = last_reg;

endmodule

### rtl/button_debounce_long_press.sv
// top level of the button debouncer with repeat and long press events
// Each accepted tick carries the raw levels of all buttons; its state update
// (edge masking, shared settle counter, per-button hold and repeat counters) is
// done in the cycle in which it is accepted, and the events it causes are queued
// as masks and sent one per cycle while event_ready is high from an output
// register, settle events first in button order, then repeat and long press per
// button. The back end loads a tick's masks before it sends that tick's events;
// its single event port sets the sustained rate, and ticks keep being taken
// while the two-entry queue has room. Configuration writes take effect at once;
// there is no read-back.
module button_debounce_long_press
    import bdlp_pkg::*;
#(
    parameter int NUM_BUTTONS = DEF_NUM_BUTTONS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
    parameter int IW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_data,
    input  logic                       tick_valid,
    output logic                       tick_ready,
    input  logic [NUM_BUTTONS-1:0]     button_levels,
    output logic                       event_valid,
    input  logic                       event_ready,
    output logic [IW-1:0]              button_index,
    output logic [1:0]                 event_kind,
    output logic                       last_event
);

    cfg_t                     cfg_reg;
    logic                     tick_fire;
    logic                     push;
    logic [4*NUM_BUTTONS-1:0] push_data;
    logic                     q_full;
    logic                     q_pop;
    logic                     q_not_empty;
    logic [4*NUM_BUTTONS-1:0] q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_ticks <= SETTLE_RESET;
            cfg_reg.repeat_ticks <= REPEAT_RESET;
            cfg_reg.long_ticks <= LONG_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SETTLE_TICKS: cfg_reg.settle_ticks <= cfg_data;
                REG_REPEAT_TICKS: cfg_reg.repeat_ticks <= cfg_data;
                REG_LONG_TICKS:   cfg_reg.long_ticks <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign tick_ready = !q_full;
    assign tick_fire = tick_valid && tick_ready;

    bdlp_front #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .tick_fire (tick_fire),
        .levels    (button_levels),
        .push      (push),
        .push_data (push_data)
    );

    bdlp_queue #(
        .WIDTH (4 * NUM_BUTTONS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    bdlp_back #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .IW          (IW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .event_valid  (event_valid),
        .event_ready  (event_ready),
        .button_index (button_index),
        .event_kind   (event_kind),
        .last_event   (last_event)
    );

endmodule
